>>> rtl/core/see_pkg.sv
// ----------------------------------------------------------------------------
// see_pkg
// shared types and helpers for the string escape encoder
// ----------------------------------------------------------------------------
package see_pkg;

	localparam int unsigned QDepth = 2;
	localparam int unsigned QAw    = $clog2(QDepth);

	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChQuote     = 8'h22;
	localparam logic [7:0] ChX         = 8'h78;
	localparam logic [7:0] CtrlLimit   = 8'h20;

	// escape class of one text byte
	typedef enum logic [1:0] {
		KIND_PLAIN,
		KIND_SHORT,
		KIND_HEX
	} kind_t;

	// classified request passed from front to back
	typedef struct packed {
		kind_t      kind;
		logic [7:0] sym;        // plain byte, escape letter or raw control byte
		logic       string_end;
	} entry_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] nib);
		logic [7:0] r;
		if (nib < 4'd10) begin
			r = 8'h30 + {4'd0, nib};
		end else begin
			r = 8'h57 + {4'd0, nib};
		end
		return r;
	endfunction

endpackage

>>> rtl/core/see_front.sv
// ----------------------------------------------------------------------------
// see_front
// classifies each incoming text byte into plain, short escape or hex escape
// ----------------------------------------------------------------------------
module see_front
	import see_pkg::*;
(
	input  logic [7:0] text_byte,
	input  logic       string_end,
	output entry_t     entry
);

	always_comb begin
		entry.string_end = string_end;
		entry.sym        = text_byte;
		entry.kind       = KIND_PLAIN;
		unique case (text_byte) inside
			8'h0A: begin entry.kind = KIND_SHORT; entry.sym = 8'h6E; end // n
			8'h0D: begin entry.kind = KIND_SHORT; entry.sym = 8'h72; end // r
			8'h09: begin entry.kind = KIND_SHORT; entry.sym = 8'h74; end // t
			8'h08: begin entry.kind = KIND_SHORT; entry.sym = 8'h62; end // b
			8'h0C: begin entry.kind = KIND_SHORT; entry.sym = 8'h66; end // f
			ChQuote,
			ChBackslash: begin
				entry.kind = KIND_SHORT;
			end
			default: begin
				if (text_byte < CtrlLimit) begin
					entry.kind = KIND_HEX;
				end
			end
		endcase
	end

endmodule

>>> rtl/core/see_queue.sv
// ----------------------------------------------------------------------------
// see_queue
// small fifo of classified requests between front and back
// ----------------------------------------------------------------------------
module see_queue
	import see_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	input  logic   pop,
	output entry_t head,
	output logic   empty,
	output logic   full
);

	entry_t            mem_q [QDepth];
	logic [QAw-1:0]    wr_ptr_q;
	logic [QAw-1:0]    rd_ptr_q;
	logic [QAw:0]      count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (QAw+1)'(QDepth));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAw'(QDepth-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAw'(QDepth-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/core/see_back.sv
// ----------------------------------------------------------------------------
// see_back
// expands the head request into output bytes, one per cycle while not empty
// ----------------------------------------------------------------------------
module see_back
	import see_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     head,
	input  logic       empty,
	output logic       pop,
	output logic       strobe,
	output logic [7:0] escaped_byte,
	output logic       run_last,
	output logic       string_done
);

	logic [1:0] idx_q;
	logic [7:0] byte_c;
	logic       last_c;
	logic       strobe_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       done_q;

	// byte and end-of-run for the current position in the run
	always_comb begin
		byte_c = ChBackslash;
		last_c = 1'b0;
		case (head.kind)
			KIND_PLAIN: begin
				byte_c = head.sym;
				last_c = 1'b1;
			end
			KIND_SHORT: begin
				if (idx_q != 2'd0) begin
					byte_c = head.sym;
					last_c = 1'b1;
				end
			end
			KIND_HEX: begin
				case (idx_q)
					2'd0:    byte_c = ChBackslash;
					2'd1:    byte_c = ChX;
					2'd2:    byte_c = hex_digit(head.sym[7:4]);
					default: begin
						byte_c = hex_digit(head.sym[3:0]);
						last_c = 1'b1;
					end
				endcase
			end
			default: begin
				byte_c = head.sym;
				last_c = 1'b1;
			end
		endcase
	end

	assign pop = !empty && last_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= !empty;
			if (!empty) begin
				idx_q <= last_c ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!empty) begin
			byte_q <= byte_c;
			last_q <= last_c;
			done_q <= last_c && head.string_end;
		end
	end

	assign strobe       = strobe_q;
	assign escaped_byte = byte_q;
	assign run_last     = last_q;
	assign string_done  = done_q;

endmodule

>>> rtl/core/string_escape_encoder_core.sv
// ----------------------------------------------------------------------------
// string_escape_encoder_core
// c-style escaping of a byte stream: one text byte in, a run of 1, 2 or 4
// escaped bytes out
// ----------------------------------------------------------------------------
//
// channel   | handshake        | payload
// ----------+------------------+-----------------------------------------
// request   | start / busy     | text_byte[7:0], string_end
// result    | strobe (1 cycle) | escaped_byte[7:0], run_last, string_done
//
// a request is written into the queue at its accepting edge; once it is the
// queue head, its first byte passes the registered output and is strobed
// plain bytes sustain one request per cycle; a short or hex escape holds the
// back end for its whole escaped run, the output byte rate being the limit
// the two-entry queue lets the front keep accepting while the back expands
// busy rises only when the queue is full; results cannot be held off
// reset clears queue pointers, run position and strobe
//
module string_escape_encoder_core
	import see_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] text_byte,
	input  logic       string_end,
	output logic       strobe,
	output logic [7:0] escaped_byte,
	output logic       run_last,
	output logic       string_done
);

	entry_t entry;      // classified request from the front
	entry_t head;       // oldest queued request
	logic   q_empty;
	logic   q_full;
	logic   q_pop;
	logic   accept;

	// front: pure classification of the incoming byte
	see_front u_front (
		.text_byte  (text_byte),
		.string_end (string_end),
		.entry      (entry)
	);

	assign busy   = q_full;
	assign accept = start && !q_full;

	// decoupling queue between classify and expand
	see_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (entry),
		.pop       (q_pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	// back: walks each request through its byte run
	see_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (q_empty),
		.pop          (q_pop),
		.strobe       (strobe),
		.escaped_byte (escaped_byte),
		.run_last     (run_last),
		.string_done  (string_done)
	);

endmodule

>>> tb/string_escape_encoder_core_tb.sv
// ----------------------------------------------------------------------------
// string_escape_encoder_core_tb
// self-checking bench for the c-style string escape encoder: a queue-fed
// driver sends text bytes in random bursts, a behavioral encoder predicts the
// escaped runs, and a monitor compares every strobed byte with them
// ----------------------------------------------------------------------------
module string_escape_encoder_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import see_pkg::*;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned RandomCount = 380;
	localparam int unsigned DrainCycles = 8;

	// control bytes with a two-byte escape, the DEL byte and the escape letters
	localparam logic [7:0] ChBs   = 8'h08;
	localparam logic [7:0] ChTab  = 8'h09;
	localparam logic [7:0] ChLf   = 8'h0A;
	localparam logic [7:0] ChFf   = 8'h0C;
	localparam logic [7:0] ChCr   = 8'h0D;
	localparam logic [7:0] ChDel  = 8'h7F;
	localparam logic [7:0] LetN   = 8'h6E;
	localparam logic [7:0] LetR   = 8'h72;
	localparam logic [7:0] LetT   = 8'h74;
	localparam logic [7:0] LetB   = 8'h62;
	localparam logic [7:0] LetF   = 8'h66;

	// one text byte waiting to be sent
	typedef struct packed {
		logic [7:0] text;
		logic       eos;
	} text_req_t;

	// one escaped byte as the block should strobe it
	typedef struct packed {
		logic [7:0] ch;
		logic       run_end;
		logic       str_done;
	} esc_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [7:0] text_byte = 8'h00;
	logic       string_end = 1'b0;
	logic       strobe;
	logic [7:0] escaped_byte;
	logic       run_last;
	logic       string_done;

	text_req_t text_q[$];
	esc_byte_t escaped_q[$];

	int unsigned cycles = 0;
	int unsigned errors = 0;
	int unsigned bytes_checked = 0;
	int unsigned n_plain = 0;
	int unsigned n_short = 0;
	int unsigned n_hex = 0;
	int unsigned n_eos = 0;

	// sender burst / gap shaping
	int unsigned burst_left = 4;
	int unsigned gap_left = 0;
	logic        took;
	logic        next_start;

	string_escape_encoder_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.text_byte    (text_byte),
		.string_end   (string_end),
		.strobe       (strobe),
		.escaped_byte (escaped_byte),
		.run_last     (run_last),
		.string_done  (string_done)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// lowercase hex digit of a nibble
	function automatic logic [7:0] nibble_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return 8'h30 + {4'd0, nib};
		end
		return 8'h61 + {4'd0, nib} - 8'd10;
	endfunction

	// escape class and short-escape letter of a text byte
	function automatic kind_t classify_text(input logic [7:0] ch, output logic [7:0] letter);
		letter = ch;
		case (ch)
			ChLf:        letter = LetN;
			ChCr:        letter = LetR;
			ChTab:       letter = LetT;
			ChBs:        letter = LetB;
			ChFf:        letter = LetF;
			ChQuote,
			ChBackslash: letter = ch;
			default: begin
				if (ch < CtrlLimit) begin
					return KIND_HEX;
				end
				return KIND_PLAIN;
			end
		endcase
		return KIND_SHORT;
	endfunction

	// append the escaped run of one accepted request to the expected bytes
	function automatic void encode_escape(input text_req_t req);
		logic [7:0] letter;
		kind_t      kind;
		kind = classify_text(req.text, letter);
		// string_done only ever rides on the final byte of the run
		case (kind)
			KIND_SHORT: begin
				escaped_q.push_back('{ChBackslash, 1'b0, 1'b0});
				escaped_q.push_back('{letter, 1'b1, req.eos});
				n_short++;
			end
			KIND_HEX: begin
				escaped_q.push_back('{ChBackslash, 1'b0, 1'b0});
				escaped_q.push_back('{ChX, 1'b0, 1'b0});
				escaped_q.push_back('{nibble_char(req.text[7:4]), 1'b0, 1'b0});
				escaped_q.push_back('{nibble_char(req.text[3:0]), 1'b1, req.eos});
				n_hex++;
			end
			default: begin
				escaped_q.push_back('{req.text, 1'b1, req.eos});
				n_plain++;
			end
		endcase
		if (req.eos) begin
			n_eos++;
		end
	endfunction

	function automatic void add_text(input logic [7:0] ch, input logic eos);
		text_q.push_back('{ch, eos});
	endfunction

	// random text byte weighted toward the interesting classes
	function automatic logic [7:0] pick_text();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2: return 8'($urandom_range(0, 31));
			3: begin
				case ($urandom_range(0, 6))
					0: return ChLf;
					1: return ChCr;
					2: return ChTab;
					3: return ChBs;
					4: return ChFf;
					5: return ChQuote;
					default: return ChBackslash;
				endcase
			end
			4: begin
				case ($urandom_range(0, 4))
					0: return 8'h1F;
					1: return CtrlLimit;
					2: return ChDel;
					3: return 8'h80;
					default: return 8'hFF;
				endcase
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// driver: requests from text_q, sent in bursts with random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			took = start && !busy;
			next_start = 1'b0;
			if (took) begin
				encode_escape(text_q.pop_front());
				if (burst_left != 0) begin
					burst_left--;
				end
				if (burst_left == 0) begin
					// mostly short gaps, now and then a long one; long bursts give
					// stretches where the sender never idles
					gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
						: $urandom_range(0, 3);
					burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 8);
				end
			end
			if (start && !took) begin
				// request still pending, hold it
				next_start = 1'b1;
			end else if (gap_left != 0) begin
				gap_left--;
			end else if (text_q.size() != 0) begin
				next_start = 1'b1;
			end
			start <= next_start;
			if (next_start) begin
				text_byte  <= text_q[0].text;
				string_end <= text_q[0].eos;
			end else begin
				// junk on the payload while start is low must be ignored
				text_byte  <= 8'($urandom);
				string_end <= 1'($urandom);
			end
		end
	end

	// monitor: every strobed byte against the oldest expectation
	always @(posedge clk) begin
		esc_byte_t want;
		if (arst_n && strobe) begin
			if (escaped_q.size() == 0) begin
				$display("%0t: unexpected result byte=%h last=%b done=%b", $time,
					escaped_byte, run_last, string_done);
				errors++;
			end else begin
				want = escaped_q.pop_front();
				bytes_checked++;
				if (escaped_byte !== want.ch) begin
					$display("%0t: escaped_byte expected %h actual %h", $time,
						want.ch, escaped_byte);
					errors++;
				end
				if (run_last !== want.run_end) begin
					$display("%0t: run_last expected %b actual %b", $time,
						want.run_end, run_last);
					errors++;
				end
				if (string_done !== want.str_done) begin
					$display("%0t: string_done expected %b actual %b", $time,
						want.str_done, string_done);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles == CycleLimit) begin
			$display("%0t: timeout, %0d bytes still expected", $time, escaped_q.size());
			$display("FAIL string_escape_encoder_core");
			$finish;
		end
	end

	initial begin
		// directed: every short escape, hex extremes, zero byte, plain boundaries
		add_text(8'h00, 1'b0);
		add_text(ChLf, 1'b0);
		add_text(ChCr, 1'b1);
		add_text(ChTab, 1'b0);
		add_text(ChBs, 1'b1);
		add_text(ChFf, 1'b0);
		add_text(ChQuote, 1'b1);
		add_text(ChBackslash, 1'b0);
		add_text(8'h1F, 1'b1);
		add_text(8'h01, 1'b0);
		add_text(8'h0B, 1'b0);
		add_text(8'h10, 1'b1);
		add_text(8'h1B, 1'b0);
		add_text(CtrlLimit, 1'b0);
		add_text(8'h21, 1'b1);
		add_text(8'h41, 1'b0);
		add_text(8'h7E, 1'b0);
		add_text(ChDel, 1'b1);
		add_text(8'h80, 1'b0);
		add_text(8'hAA, 1'b1);
		add_text(8'h55, 1'b0);
		add_text(8'hFF, 1'b1);
		add_text(8'h00, 1'b1);
		for (int i = 0; i < RandomCount; i++) begin
			add_text(pick_text(), $urandom_range(0, 3) == 0);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (text_q.size() != 0 || start || escaped_q.size() != 0) begin
			@(posedge clk);
		end
		// drain for DrainCycles so a stray trailing strobe would be caught
		repeat (DrainCycles) @(posedge clk);

		$display("covered %0d plain, %0d short-escape and %0d hex-escape requests",
			n_plain, n_short, n_hex);
		$display("%0d string ends, %0d escaped bytes checked, %0d errors",
			n_eos, bytes_checked, errors);
		if (errors == 0 && escaped_q.size() == 0) begin
			$display("PASS string_escape_encoder_core");
		end else begin
			$display("FAIL string_escape_encoder_core");
		end
		$finish;
	end

endmodule
